// ----- rtl/dvpcap_pkg.sv -----
`timescale 1ns / 1ps

package dvpcap_pkg;

	// Default width of the framebuffer byte address.
	localparam int ADDR_BITS_DEF = 27;

	// Configuration port geometry.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Field widths.
	localparam int COUNT_W  = 11;
	localparam int OFFSET_W = 12;
	localparam int PITCH_W  = 15;
	localparam int ROWSUM_W = 13;

	// Pixel packing constants.
	localparam logic [7:0] PIX_TOP_BYTE = 8'hF0;
	localparam logic [7:0] RED_MASK     = 8'hF8;

	// Register reset values.
	localparam logic [COUNT_W-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [COUNT_W-1:0]  HEIGHT_RST = 11'd480;
	localparam logic [OFFSET_W-1:0] SBR_RST    = 12'd480;
	localparam logic [PITCH_W-1:0]  PITCH_RST  = 15'd2560;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_ACTIVE_WIDTH  = 2'd0,
		REG_ACTIVE_HEIGHT = 2'd1,
		REG_SECOND_ROW    = 2'd2,
		REG_ROW_PITCH     = 2'd3
	} reg_idx_t;

	// Capture modes.
	typedef enum logic [1:0] {
		MODE_WAIT_FRAME = 2'd0,
		MODE_WAIT_LINE  = 2'd1,
		MODE_LINE       = 2'd2
	} mode_t;

	// Current configuration.
	typedef struct packed {
		logic [COUNT_W-1:0]  active_width;
		logic [COUNT_W-1:0]  active_height;
		logic [OFFSET_W-1:0] second_buffer_row;
		logic [PITCH_W-1:0]  row_pitch_bytes;
	} cfg_t;

	// One pixel write on its way to the address stage.
	typedef struct packed {
		logic [ROWSUM_W-1:0] row;
		logic [COUNT_W-1:0]  col;
		logic [PITCH_W-1:0]  pitch;
		logic [31:0]         word;
		logic                done;
		logic [OFFSET_W-1:0] offset;
	} pix_t;

	// Packs two RGB565 bytes into an F0:R:G:B word.
	function automatic logic [31:0] pack_pixel(input logic [7:0] b1, input logic [7:0] b2);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		r = b1 & RED_MASK;
		g = {b1[2:0], b2[7:5], 2'b00};
		b = {b2[4:0], 3'b000};
		return {PIX_TOP_BYTE, r, g, b};
	endfunction

endpackage

// ----- rtl/dvpcap_regs.sv -----
`timescale 1ns / 1ps

module dvpcap_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dvpcap_pkg::PADDR_W-1:0] paddr,
	input  logic [dvpcap_pkg::PDATA_W-1:0] pwdata,
	output logic [dvpcap_pkg::PDATA_W-1:0] prdata,
	output logic                           pready,
	output dvpcap_pkg::cfg_t               cfg
);
	import dvpcap_pkg::*;

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign cfg    = cfg_q;

	// Register writes, taken in the access cycle of a write transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_width      <= WIDTH_RST;
			cfg_q.active_height     <= HEIGHT_RST;
			cfg_q.second_buffer_row <= SBR_RST;
			cfg_q.row_pitch_bytes   <= PITCH_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_ACTIVE_WIDTH:  cfg_q.active_width      <= pwdata[COUNT_W-1:0];
				REG_ACTIVE_HEIGHT: cfg_q.active_height     <= pwdata[COUNT_W-1:0];
				REG_SECOND_ROW:    cfg_q.second_buffer_row <= pwdata[OFFSET_W-1:0];
				REG_ROW_PITCH:     cfg_q.row_pitch_bytes   <= pwdata[PITCH_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data, zero extended.
	always_comb begin
		unique case (idx)
			REG_ACTIVE_WIDTH:  prdata = PDATA_W'(cfg_q.active_width);
			REG_ACTIVE_HEIGHT: prdata = PDATA_W'(cfg_q.active_height);
			REG_SECOND_ROW:    prdata = PDATA_W'(cfg_q.second_buffer_row);
			REG_ROW_PITCH:     prdata = PDATA_W'(cfg_q.row_pitch_bytes);
			default:           prdata = '0;
		endcase
	end

endmodule

// ----- rtl/dvpcap_ctrl.sv -----
`timescale 1ns / 1ps

module dvpcap_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  dvpcap_pkg::cfg_t cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             vsync_level,
	input  logic             hsync_level,
	input  logic             pixclk_level,
	input  logic [7:0]       data_byte,
	input  logic             adv_s2,
	output logic             valid_s1,
	output dvpcap_pkg::pix_t pix_s1
);
	import dvpcap_pkg::*;

	mode_t                mode_q;
	mode_t                mode_d;
	logic                 last_vsync_q;
	logic                 last_hsync_q;
	logic                 last_pixclk_q;
	logic                 phase_q;
	logic [7:0]           held_q;
	logic [COUNT_W-1:0]   col_q;
	logic [COUNT_W-1:0]   line_q;
	logic [OFFSET_W-1:0]  offset_q;

	logic                 acc;
	logic                 adv_s1;
	logic                 vs_fall;
	logic                 hs_rise;
	logic                 pc_rise;
	logic                 start_frame;
	logic                 start_line;
	logic                 first_byte;
	logic                 emit;
	logic                 col_end;
	logic                 line_end;
	logic [COUNT_W-1:0]   next_col;
	logic [COUNT_W-1:0]   next_line;

	// The stage register frees up when it is empty or moves on this cycle.
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;
	assign acc      = in_valid && adv_s1;

	assign vs_fall   = last_vsync_q && !vsync_level;
	assign hs_rise   = !last_hsync_q && hsync_level;
	assign pc_rise   = !last_pixclk_q && pixclk_level;
	assign next_col  = col_q + 1'b1;
	assign next_line = line_q + 1'b1;
	assign col_end   = (next_col == cfg.active_width);
	assign line_end  = (next_line == cfg.active_height);

	// Next capture mode.
	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			MODE_WAIT_LINE: begin
				if (hs_rise) mode_d = MODE_LINE;
			end
			MODE_LINE: begin
				if (pc_rise && phase_q && col_end)
					mode_d = line_end ? MODE_WAIT_FRAME : MODE_WAIT_LINE;
			end
			default: begin
				mode_d = vs_fall ? MODE_WAIT_LINE : MODE_WAIT_FRAME;
			end
		endcase
	end

	// Actions decoded from the current mode.
	always_comb begin
		start_frame = 1'b0;
		start_line  = 1'b0;
		first_byte  = 1'b0;
		emit        = 1'b0;
		unique case (mode_q)
			MODE_WAIT_LINE: start_line = hs_rise;
			MODE_LINE: begin
				first_byte = pc_rise && !phase_q;
				emit       = pc_rise && phase_q;
			end
			default: start_frame = vs_fall;
		endcase
	end

	// Capture state, updated once per accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_WAIT_FRAME;
			last_vsync_q  <= 1'b0;
			last_hsync_q  <= 1'b0;
			last_pixclk_q <= 1'b0;
			phase_q       <= 1'b0;
			held_q        <= '0;
			col_q         <= '0;
			line_q        <= '0;
			offset_q      <= '0;
		end else if (acc) begin
			mode_q        <= mode_d;
			last_vsync_q  <= vsync_level;
			last_hsync_q  <= hsync_level;
			last_pixclk_q <= pixclk_level;
			if (start_frame) begin
				offset_q <= (offset_q == '0) ? cfg.second_buffer_row : '0;
				line_q   <= '0;
				col_q    <= '0;
				phase_q  <= 1'b0;
			end
			if (start_line) begin
				col_q   <= '0;
				phase_q <= 1'b0;
			end
			if (first_byte) begin
				held_q  <= data_byte;
				phase_q <= 1'b1;
			end
			if (emit) begin
				phase_q <= 1'b0;
				if (col_end) begin
					col_q  <= '0;
					line_q <= line_end ? '0 : next_line;
				end else begin
					col_q <= next_col;
				end
			end
		end
	end

	// Stage one: the pixel write with its row, column and pitch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= acc && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && emit) begin
			pix_s1.row    <= ROWSUM_W'(line_q) + ROWSUM_W'(offset_q);
			pix_s1.col    <= col_q;
			pix_s1.pitch  <= cfg.row_pitch_bytes;
			pix_s1.word   <= pack_pixel(held_q, data_byte);
			pix_s1.done   <= col_end && line_end;
			pix_s1.offset <= offset_q;
		end
	end

`ifndef SYNTHESIS
	a_emit_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		acc && emit |-> mode_q == MODE_LINE)
		else $error("pixel write outside a line");

	a_done_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		acc && emit && col_end && line_end |=> mode_q == MODE_WAIT_FRAME)
		else $error("frame done without return to frame wait");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1)
		else $error("stage one lost a pending pixel");
`endif

endmodule

// ----- rtl/dvpcap_out.sv -----
`timescale 1ns / 1ps

module dvpcap_out #(
	parameter int ADDR_BITS = dvpcap_pkg::ADDR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            valid_s1,
	input  dvpcap_pkg::pix_t                pix_s1,
	output logic                            adv_s2,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ADDR_BITS-1:0]            write_addr,
	output logic [31:0]                     pixel_word,
	output logic                            frame_done,
	output logic [dvpcap_pkg::OFFSET_W-1:0] display_row_offset
);
	import dvpcap_pkg::*;

	localparam int PROD_W = ROWSUM_W + PITCH_W;
	localparam int SUM_W  = PROD_W + 1;

	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  addr_sum;
	logic [63:0]       addr_wide;

	// Row base times pitch plus four bytes per column, taken modulo the bus.
	assign prod      = PROD_W'(pix_s1.row) * PROD_W'(pix_s1.pitch);
	assign addr_sum  = SUM_W'(prod) + SUM_W'({pix_s1.col, 2'b00});
	assign addr_wide = 64'(addr_sum);

	assign adv_s2 = !out_valid || !out_stall;

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv_s2) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			write_addr         <= addr_wide[ADDR_BITS-1:0];
			pixel_word         <= pix_s1.word;
			frame_done         <= pix_s1.done;
			display_row_offset <= pix_s1.offset;
		end
	end

`ifndef SYNTHESIS
	a_fill_empty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_valid |=> out_valid)
		else $error("result register did not take a pending pixel");

	a_word_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_word[31:24] == PIX_TOP_BYTE)
		else $error("pixel word top byte corrupted");
`endif

endmodule

// ----- rtl/parallel_camera_frame_capture_core.sv -----
`timescale 1ns / 1ps

// Parallel camera frame capture. Each input transaction is one sample of the
// camera pins (vsync, hsync, pixel clock, data byte); send one per clock.
// A falling vsync starts a frame and flips the buffer row offset between 0
// and second_buffer_row; each line starts on a rising hsync; two bytes taken
// on rising pixel-clock edges form one RGB565 pixel.
// Each pixel leaves as one output transaction: a 32-bit F0:R:G:B word, its
// framebuffer byte address, frame_done on the last pixel of the frame and
// the buffer row offset in use.
// A pixel is registered in stage one and then in the result register after the
// transaction that carries its second byte. Throughput: one input transaction per
// cycle while the input is not stalled, set by the capture state register that
// every sample updates. When the receiver stalls, the result register holds
// and the input is stalled once the stage ahead of it is also full.
// Registers are written over the APB-style port and take effect at once.
// Reset clears the capture state, empties the pipeline and loads the
// register defaults (640 x 480, second buffer at row 480, pitch 2560).

module parallel_camera_frame_capture_core #(
	parameter int ADDR_BITS = dvpcap_pkg::ADDR_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dvpcap_pkg::PADDR_W-1:0]  paddr,
	input  logic [dvpcap_pkg::PDATA_W-1:0]  pwdata,
	output logic [dvpcap_pkg::PDATA_W-1:0]  prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            vsync_level,
	input  logic                            hsync_level,
	input  logic                            pixclk_level,
	input  logic [7:0]                      data_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ADDR_BITS-1:0]            write_addr,
	output logic [31:0]                     pixel_word,
	output logic                            frame_done,
	output logic [dvpcap_pkg::OFFSET_W-1:0] display_row_offset
);
	import dvpcap_pkg::*;

	cfg_t cfg;
	pix_t pix_s1;
	logic valid_s1;
	logic adv_s2;

	dvpcap_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dvpcap_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.vsync_level  (vsync_level),
		.hsync_level  (hsync_level),
		.pixclk_level (pixclk_level),
		.data_byte    (data_byte),
		.adv_s2       (adv_s2),
		.valid_s1     (valid_s1),
		.pix_s1       (pix_s1)
	);

	dvpcap_out #(
		.ADDR_BITS (ADDR_BITS)
	) u_out (
		.clk                (clk),
		.arst_n             (arst_n),
		.valid_s1           (valid_s1),
		.pix_s1             (pix_s1),
		.adv_s2             (adv_s2),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.write_addr         (write_addr),
		.pixel_word         (pixel_word),
		.frame_done         (frame_done),
		.display_row_offset (display_row_offset)
	);

endmodule
